FILE: hdl/segment_usage_cleaner_table_macros.svh
// Assertion macros shared by the segment usage table RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef SEGMENT_USAGE_CLEANER_TABLE_MACROS_SVH
`define SEGMENT_USAGE_CLEANER_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SUT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SUT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/sut_pkg.sv
// Package of the segment usage table: sizes, codes, transaction types and
// the command and status structs between controller and datapath.
package sut_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_W        = 6;
    localparam int IDX_W        = 7;
    localparam int RAM_AW       = $clog2(MAX_SEGMENTS);
    localparam int LIVE_W       = 16;
    localparam int TIME_W       = 32;
    localparam int ENTRY_W      = LIVE_W + TIME_W;
    localparam int PROD_W       = LIVE_W + TIME_W;
    localparam int SCORE_W      = 56;
    localparam int FRAC_W       = SCORE_W - PROD_W;
    localparam int DEN_W        = LIVE_W + 1;
    localparam int CLEAN_W      = 7;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int LANES        = 8;
    localparam int LANE_CNT_W   = $clog2(LANES + 1);
    localparam int NCHUNK       = (MAX_SEGMENTS + LANES - 1) / LANES;
    localparam int CHUNK_W      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INUSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BPS   = 2'd2;

    localparam logic [1:0] KIND_LIVE   = 2'd0;
    localparam logic [1:0] KIND_DIE    = 2'd1;
    localparam logic [1:0] KIND_SELECT = 2'd2;
    localparam logic [1:0] KIND_LIST   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_LOG = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SEG_W-1:0]  segment;
        logic [TIME_W-1:0] block_time;
        logic [TIME_W-1:0] now_time;
        logic [SEG_W-1:0]  skip_segment;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [SEG_W-1:0]   result_segment;
        logic [SCORE_W-1:0] score;
        logic [LIVE_W-1:0]  live_count;
        logic [CLEAN_W-1:0] clean_count;
        logic               last;
    } t_out_item;

    typedef enum logic [1:0] {
        EMIT_UPD,
        EMIT_SEL,
        EMIT_MID,
        EMIT_END
    } t_emit;

    typedef struct packed {
        logic  take;
        logic  rd;
        logic  reject;
        logic  upd;
        logic  cnt_step;
        logic  scan_init;
        logic  sel_rd;
        logic  sel_mul;
        logic  div_start;
        logic  sel_cmp;
        logic  idx_inc;
        logic  pend_set;
        logic  emit;
        t_emit emit_kind;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       seg_log;
        logic       cnt_done;
        logic       idx_end;
        logic       idx_nz;
        logic       idx_qual;
        logic       have_pend;
        logic       div_done;
        logic       out_free;
    } t_sts;

endpackage

FILE: hdl/sut_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stands alone; no package needed.
module sut_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/sut_div.sv
// Restoring divider, one quotient bit per cycle, for the cleaning score.
// Depends on sut_pkg for the numerator and divisor widths.
module sut_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sut_pkg::SCORE_W-1:0] i_num,
    input  logic [sut_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [sut_pkg::SCORE_W-1:0] o_quot
);
    import sut_pkg::*;

    localparam int CNT_W = $clog2(SCORE_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [SCORE_W-1:0] r_num;
    logic [SCORE_W-1:0] r_quot;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W:0]     w_trial;
    logic               w_fit;

    assign w_trial = {r_rem, r_num[SCORE_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SCORE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[SCORE_W-2:0], 1'b0};
            r_quot <= {r_quot[SCORE_W-2:0], w_fit};
            r_rem  <= w_fit ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

FILE: hdl/sut_dp.sv
// Datapath of the segment usage table: configuration, table RAM, live flags,
// clean counter, score unit, scan index and output register. Uses sut_pkg,
// sut_ram and sut_div.
module sut_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sut_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sut_pkg::CFG_W-1:0]     i_cfg_data,
    input  sut_pkg::t_in_item             i_in_data,
    input  sut_pkg::t_cmd                 i_cmd,
    output sut_pkg::t_sts                 o_sts,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output sut_pkg::t_out_item            o_out_data
);
    import sut_pkg::*;

    logic [SEG_W-1:0]        r_first;
    logic [IDX_W-1:0]        r_inuse;
    logic [LIVE_W-1:0]       r_bps;
    logic [IDX_W-1:0]        w_lim;
    t_in_item                r_item;
    logic [MAX_SEGMENTS-1:0] r_nz;
    logic [MAX_SEGMENTS-1:0] r_vld;
    logic                    r_rd_ok;
    logic [ENTRY_W-1:0]      w_rdata;
    logic [LIVE_W-1:0]       w_cur_live;
    logic [TIME_W-1:0]       w_cur_time;
    logic                    w_re;
    logic [RAM_AW-1:0]       w_raddr;
    logic                    w_we;
    logic [LIVE_W-1:0]       w_wlive;
    logic [TIME_W-1:0]       w_wtime;
    logic [RAM_AW-1:0]       w_seg_a;
    logic [1:0]              r_upd_status;
    logic [LIVE_W-1:0]       r_upd_live;
    logic [CHUNK_W-1:0]      r_chunk;
    logic [CLEAN_W-1:0]      r_clean;
    logic [LANE_CNT_W-1:0]   w_chunk_cnt;
    logic [IDX_W-1:0]        r_idx;
    logic [RAM_AW-1:0]       w_idx_a;
    logic [PROD_W-1:0]       r_prod;
    logic [DEN_W-1:0]        r_den;
    logic [LIVE_W-1:0]       r_cand_live;
    logic [SEG_W-1:0]        r_cand_seg;
    logic [LIVE_W-1:0]       w_free;
    logic [TIME_W-1:0]       w_age;
    logic                    w_div_done;
    logic [SCORE_W-1:0]      w_quot;
    logic [SCORE_W-1:0]      w_sc;
    logic                    r_found;
    logic [SCORE_W-1:0]      r_best;
    logic [SEG_W-1:0]        r_best_seg;
    logic [LIVE_W-1:0]       r_best_live;
    logic                    r_have;
    logic [SEG_W-1:0]        r_pend;
    logic                    r_out_valid;
    t_out_item               r_out;

    assign w_lim   = (r_inuse > IDX_W'(MAX_SEGMENTS)) ? IDX_W'(MAX_SEGMENTS) : r_inuse;
    assign w_seg_a = r_item.segment[RAM_AW-1:0];
    assign w_idx_a = r_idx[RAM_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= SEG_W'(1);
            r_inuse <= IDX_W'(64);
            r_bps   <= LIVE_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRST: r_first <= i_cfg_data[SEG_W-1:0];
                CFG_INUSE: r_inuse <= i_cfg_data[IDX_W-1:0];
                CFG_BPS:   r_bps   <= i_cfg_data[LIVE_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_re    = i_cmd.rd | i_cmd.sel_rd;
    assign w_raddr = i_cmd.rd ? w_seg_a : w_idx_a;

    sut_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_SEGMENTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_seg_a),
        .i_wdata({w_wlive, w_wtime}),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_cur_live = r_rd_ok ? w_rdata[ENTRY_W-1 -: LIVE_W] : '0;
    assign w_cur_time = r_rd_ok ? w_rdata[TIME_W-1:0] : '0;

    always_comb begin
        w_wtime = w_cur_time;
        if (r_item.kind == KIND_LIVE) begin
            w_we    = i_cmd.upd;
            w_wlive = (w_cur_live == '1) ? w_cur_live : w_cur_live + 1'b1;
            if (r_item.block_time > w_cur_time) begin
                w_wtime = r_item.block_time;
            end
        end else begin
            w_we    = i_cmd.upd && (w_cur_live != '0);
            w_wlive = w_cur_live - 1'b1;
        end
    end

    always_comb begin
        w_chunk_cnt = '0;
        for (int j = 0; j < LANES; j++) begin
            int s;
            s = int'(r_chunk) * LANES + j;
            if (s < MAX_SEGMENTS && s >= int'(r_first) && s < int'(w_lim)
                && !r_nz[s[RAM_AW-1:0]]) begin
                w_chunk_cnt = w_chunk_cnt + 1'b1;
            end
        end
    end

    assign w_free = (r_bps > w_cur_live) ? r_bps - w_cur_live : '0;
    assign w_age  = (r_item.now_time > w_cur_time) ? r_item.now_time - w_cur_time : '0;

    sut_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  ({r_prod, {FRAC_W{1'b0}}}),
        .i_den  (r_den),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign w_sc = (r_den == '0) ? '0 : w_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz        <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_we) begin
                r_nz[w_seg_a]  <= w_wlive != '0;
                r_vld[w_seg_a] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item  <= i_in_data;
            r_chunk <= '0;
            r_clean <= '0;
        end
        if (w_re) begin
            r_rd_ok <= r_vld[w_raddr];
        end
        if (i_cmd.reject) begin
            r_upd_status <= ST_NOT_LOG;
            r_upd_live   <= '0;
        end
        if (i_cmd.upd) begin
            r_upd_status <= (r_item.kind == KIND_DIE && w_cur_live == '0) ? ST_ZERO : ST_OK;
            r_upd_live   <= w_we ? w_wlive : '0;
        end
        if (i_cmd.cnt_step) begin
            r_chunk <= r_chunk + 1'b1;
            r_clean <= r_clean + CLEAN_W'(w_chunk_cnt);
        end
        if (i_cmd.scan_init) begin
            r_idx   <= {1'b0, r_first};
            r_found <= 1'b0;
            r_have  <= 1'b0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.sel_mul) begin
            r_prod      <= w_free * w_age;
            r_den       <= {1'b0, r_bps} + {1'b0, w_cur_live};
            r_cand_live <= w_cur_live;
            r_cand_seg  <= r_idx[SEG_W-1:0];
        end
        if (i_cmd.sel_cmp && (!r_found || w_sc > r_best)) begin
            r_found     <= 1'b1;
            r_best      <= w_sc;
            r_best_seg  <= r_cand_seg;
            r_best_live <= r_cand_live;
        end
        if (i_cmd.pend_set) begin
            r_pend <= r_idx[SEG_W-1:0];
            r_have <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_out.clean_count <= r_clean;
            unique case (i_cmd.emit_kind)
                EMIT_UPD: begin
                    r_out.status         <= r_upd_status;
                    r_out.result_segment <= r_item.segment;
                    r_out.score          <= '0;
                    r_out.live_count     <= r_upd_live;
                    r_out.last           <= 1'b1;
                end
                EMIT_SEL: begin
                    r_out.status         <= r_found ? ST_OK : ST_NONE;
                    r_out.result_segment <= r_found ? r_best_seg : '0;
                    r_out.score          <= r_found ? r_best : '0;
                    r_out.live_count     <= r_found ? r_best_live : '0;
                    r_out.last           <= 1'b1;
                end
                EMIT_MID: begin
                    r_out.status         <= ST_OK;
                    r_out.result_segment <= r_pend;
                    r_out.score          <= '0;
                    r_out.live_count     <= '0;
                    r_out.last           <= 1'b0;
                end
                EMIT_END: begin
                    r_out.status         <= r_have ? ST_OK : ST_NONE;
                    r_out.result_segment <= r_have ? r_pend : '0;
                    r_out.score          <= '0;
                    r_out.live_count     <= '0;
                    r_out.last           <= 1'b1;
                end
            endcase
        end
    end

    assign o_sts.kind      = r_item.kind;
    assign o_sts.seg_log   = ({1'b0, r_item.segment} >= {1'b0, r_first})
                             && ({1'b0, r_item.segment} < w_lim);
    assign o_sts.cnt_done  = r_chunk == CHUNK_W'(NCHUNK - 1);
    assign o_sts.idx_end   = r_idx >= w_lim;
    assign o_sts.idx_nz    = r_nz[w_idx_a];
    assign o_sts.idx_qual  = !r_nz[w_idx_a] && (r_idx != {1'b0, r_item.skip_segment});
    assign o_sts.have_pend = r_have;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

FILE: hdl/sut_ctrl.sv
// Controller state machine of the segment usage table. Sequences update,
// clean count, victim scan and clean list through datapath commands.
// Uses sut_pkg and the assertion macros.
`include "segment_usage_cleaner_table_macros.svh"

module sut_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sut_pkg::t_sts i_sts,
    output sut_pkg::t_cmd o_cmd
);
    import sut_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_UPDATE,
        S_COUNT,
        S_UPD_EMIT,
        S_SEL_NEXT,
        S_SEL_MUL,
        S_SEL_DIV_GO,
        S_SEL_DIV_WAIT,
        S_SEL_EMIT,
        S_LIST_SCAN,
        S_LIST_END
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_comb begin
        w_cmd           = '0;
        w_cmd.emit_kind = EMIT_UPD;
        n_state         = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.take = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.kind == KIND_LIVE || i_sts.kind == KIND_DIE) begin
                    if (i_sts.seg_log) begin
                        w_cmd.rd = 1'b1;
                        n_state  = S_UPDATE;
                    end else begin
                        w_cmd.reject = 1'b1;
                        n_state      = S_COUNT;
                    end
                end else begin
                    n_state = S_COUNT;
                end
            end
            S_UPDATE: begin
                w_cmd.upd = 1'b1;
                n_state   = S_COUNT;
            end
            S_COUNT: begin
                w_cmd.cnt_step = 1'b1;
                if (i_sts.cnt_done) begin
                    unique case (i_sts.kind)
                        KIND_SELECT: begin
                            w_cmd.scan_init = 1'b1;
                            n_state         = S_SEL_NEXT;
                        end
                        KIND_LIST: begin
                            w_cmd.scan_init = 1'b1;
                            n_state         = S_LIST_SCAN;
                        end
                        default: n_state = S_UPD_EMIT;
                    endcase
                end
            end
            S_UPD_EMIT: begin
                if (i_sts.out_free) begin
                    w_cmd.emit      = 1'b1;
                    w_cmd.emit_kind = EMIT_UPD;
                    n_state         = S_IDLE;
                end
            end
            S_SEL_NEXT: begin
                if (i_sts.idx_end) begin
                    n_state = S_SEL_EMIT;
                end else if (!i_sts.idx_nz) begin
                    w_cmd.idx_inc = 1'b1;
                end else begin
                    w_cmd.sel_rd = 1'b1;
                    n_state      = S_SEL_MUL;
                end
            end
            S_SEL_MUL: begin
                w_cmd.sel_mul = 1'b1;
                n_state       = S_SEL_DIV_GO;
            end
            S_SEL_DIV_GO: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_SEL_DIV_WAIT;
            end
            S_SEL_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    w_cmd.sel_cmp = 1'b1;
                    w_cmd.idx_inc = 1'b1;
                    n_state       = S_SEL_NEXT;
                end
            end
            S_SEL_EMIT: begin
                if (i_sts.out_free) begin
                    w_cmd.emit      = 1'b1;
                    w_cmd.emit_kind = EMIT_SEL;
                    n_state         = S_IDLE;
                end
            end
            S_LIST_SCAN: begin
                if (i_sts.idx_end) begin
                    n_state = S_LIST_END;
                end else if (!i_sts.idx_qual) begin
                    w_cmd.idx_inc = 1'b1;
                end else if (!i_sts.have_pend) begin
                    w_cmd.pend_set = 1'b1;
                    w_cmd.idx_inc  = 1'b1;
                end else if (i_sts.out_free) begin
                    w_cmd.emit      = 1'b1;
                    w_cmd.emit_kind = EMIT_MID;
                    w_cmd.pend_set  = 1'b1;
                    w_cmd.idx_inc   = 1'b1;
                end
            end
            S_LIST_END: begin
                if (i_sts.out_free) begin
                    w_cmd.emit      = 1'b1;
                    w_cmd.emit_kind = EMIT_END;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = r_state != S_IDLE;

    `SUT_ASSERT_IMP(a_emit_needs_room, w_cmd.emit, i_sts.out_free)
    `SUT_ASSERT_NEXT(a_take_dispatches, w_cmd.take, r_state == S_DISPATCH)
    `SUT_ASSERT_NEXT(a_div_holds, (r_state == S_SEL_DIV_WAIT) && !i_sts.div_done,
                     r_state == S_SEL_DIV_WAIT)
endmodule

FILE: hdl/segment_usage_cleaner_table.sv
// Segment usage table with a cost-benefit cleaner. One transaction is taken
// at a time: a live or die update does a table read and write, then a clean
// count over the live flags eight segments per cycle; select does the same
// count, then skips each empty log segment and scores each segment with
// live blocks through the one-bit-per-cycle score divider; list does the
// count, then walks the log segments. The table is cleared at reset by
// per-entry valid flags, so no clearing pass is needed. Depends on sut_pkg,
// sut_ctrl and sut_dp.
module segment_usage_cleaner_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sut_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sut_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sut_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sut_pkg::t_out_item            o_out_data
);
    import sut_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sut_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    sut_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );
endmodule
